>>> sv/rsi_pkg.sv
// rsi_pkg: widths, stage types and constants for the ray-sphere intersection pipeline.
// Used by ray_sphere_intersect and its port checker; depends on nothing.
`default_nettype none
package rsi_pkg;
   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int DIR_W     = 18;
   localparam int RAD_W     = 31;
   localparam int DIST_W    = 32;
   localparam int OC_W      = CRD_W + 1;
   localparam int PD_W      = DIR_W + OC_W;
   localparam int HD_W      = PD_W + 2;
   localparam int HM_W      = HD_W;
   localparam int LO_W      = (HM_W + 1) / 2;
   localparam int HI_W      = HM_W - LO_W;
   localparam int SQ2_W     = 2 * OC_W;
   localparam int RR_W      = 2 * RAD_W;
   localparam int C_W       = SQ2_W + 2;
   localparam int HD2_W     = 2 * HM_W;
   localparam int D_RAW     = (HD2_W > C_W + 2 * FRAC_BITS) ? HD2_W : C_W + 2 * FRAC_BITS;
   localparam int D_W       = D_RAW + 2 + (D_RAW % 2);
   localparam int SQ_W      = D_W / 2;
   localparam int T_W       = ((SQ_W > HD_W) ? SQ_W : HD_W) + 2;
   localparam int REQ_W     = 3 * CRD_W + 3 * DIR_W + 3 * CRD_W + RAD_W;
   localparam int REQ_BYTES = (REQ_W + 7) / 8;
   localparam int RSP_W     = 1 + DIST_W;
   localparam int RSP_BYTES = (RSP_W + 7) / 8;

   typedef struct packed {
      logic signed [HD_W-1:0] hd;
      logic                   c_pos;
      logic                   c_neg;
      logic                   d_neg;
      logic                   d_zero;
   } side_type;
endpackage
`default_nettype wire

>>> sv/ray_sphere_intersect.sv
// ray_sphere_intersect: pipelined ray-sphere nearest-hit test, one item per cycle.
// Depends on rsi_pkg (widths and the side-data struct).
//
//  channel | ports                     | payload (lowest bit up)
//  req     | req_tvalid/tready/tdata   | origin xyz, dir xyz, center xyz, radius
//  rsp     | rsp_tvalid/tready/tdata   | hit, distance
//
// Six arithmetic stages, a sqrt load stage, one stage per root bit, the root choice
// register and the output register make up the pipeline. Throughput is one item per
// cycle unless the output stalls; the bit-serial square root pipeline sets the depth.
// Reset (synchronous, active high) clears every valid bit and the output valid.
// A stalled result freezes all stages together; nothing is lost or repeated.
`default_nettype none
module ray_sphere_intersect import rsi_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
   // center_z, sphere_radius, zero padding
   input  wire  [8*REQ_BYTES-1:0]    req_tdata,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // hit, distance, zero padding
   output logic [8*RSP_BYTES-1:0]    rsp_tdata
);
   localparam int DX = 3 * CRD_W;
   localparam int CX = DX + 3 * DIR_W;
   localparam int RX = CX + 3 * CRD_W;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vf_ff, rsp_valid_ff;

   logic signed [OC_W-1:0]  oc_ff [3];
   logic signed [DIR_W-1:0] dir_ff [3];
   logic [RAD_W-1:0]        rad_ff;
   logic signed [PD_W-1:0]  pd_ff [3];
   logic signed [SQ2_W-1:0] sq_ff [3];
   logic [RR_W-1:0]         rr_ff;
   logic signed [HD_W-1:0]  hd3_ff, hd4_ff, hd5_ff, hd6_ff;
   logic signed [C_W-1:0]   c3_ff, c4_ff;
   logic                    cpos4_ff, cneg4_ff, cpos5_ff, cneg5_ff, cpos6_ff, cneg6_ff;
   logic [2*LO_W-1:0]       pll_ff;
   logic [HI_W+LO_W-1:0]    plh_ff;
   logic [2*HI_W-1:0]       phh_ff;
   logic [HD2_W-1:0]        hd2_ff;
   logic signed [D_W-1:0]   cs_ff, d_ff;

   logic [D_W-1:0]          dsh_ff  [SQ_W+1];
   logic [SQ_W+1:0]         rem_ff  [SQ_W+1];
   logic [SQ_W-1:0]         root_ff [SQ_W+1];
   side_type                side_ff [SQ_W+1];
   logic                    vq_ff   [SQ_W+1];

   logic                    hitf_ff;
   logic signed [T_W-1:0]   tf_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic                    hit_ff;

   logic [HM_W-1:0]         hm;
   logic signed [T_W-1:0]   t_in, q;
   logic                    hit_in;
   logic [DIST_W-1:0]       dist_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8*RSP_BYTES-RSP_W){1'b0}}, dist_ff, hit_ff};

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; vf_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; vf_ff <= vq_ff[SQ_W];
         rsp_valid_ff <= vf_ff;
      end
   end

   // origin minus center, products, sums
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            oc_ff[k]  <= $signed({req_tdata[k*CRD_W+CRD_W-1], req_tdata[k*CRD_W +: CRD_W]})
                       - $signed({req_tdata[CX+k*CRD_W+CRD_W-1], req_tdata[CX+k*CRD_W +: CRD_W]});
            dir_ff[k] <= $signed(req_tdata[DX+k*DIR_W +: DIR_W]);
            pd_ff[k]  <= PD_W'(dir_ff[k] * oc_ff[k]);
            sq_ff[k]  <= SQ2_W'(oc_ff[k] * oc_ff[k]);
         end
         rad_ff <= req_tdata[RX +: RAD_W];
         rr_ff  <= RR_W'(rad_ff * rad_ff);
         hd3_ff <= HD_W'(pd_ff[0]) + HD_W'(pd_ff[1]) + HD_W'(pd_ff[2]);
         c3_ff  <= C_W'(sq_ff[0]) + C_W'(sq_ff[1]) + C_W'(sq_ff[2])
                 - $signed({{(C_W-RR_W){1'b0}}, rr_ff});
      end
   end

   // hd squared by partial products
   assign hm = hd3_ff[HD_W-1] ? HM_W'(-hd3_ff) : HM_W'(hd3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff   <= hm[LO_W-1:0] * hm[LO_W-1:0];
         plh_ff   <= hm[HM_W-1:LO_W] * hm[LO_W-1:0];
         phh_ff   <= hm[HM_W-1:LO_W] * hm[HM_W-1:LO_W];
         hd4_ff   <= hd3_ff;
         c4_ff    <= c3_ff;
         cpos4_ff <= !c3_ff[C_W-1] && (c3_ff != '0);
         cneg4_ff <= c3_ff[C_W-1];
         hd2_ff   <= {phh_ff, {(2*LO_W){1'b0}}}
                   + ({{(HD2_W-HI_W-LO_W){1'b0}}, plh_ff} << (LO_W + 1))
                   + {{(HD2_W-2*LO_W){1'b0}}, pll_ff};
         cs_ff    <= D_W'(c4_ff) <<< (2 * FRAC_BITS);
         hd5_ff   <= hd4_ff;
         cpos5_ff <= cpos4_ff;
         cneg5_ff <= cneg4_ff;
         d_ff     <= $signed({{(D_W-HD2_W){1'b0}}, hd2_ff}) - cs_ff;
         hd6_ff   <= hd5_ff;
         cpos6_ff <= cpos5_ff;
         cneg6_ff <= cneg5_ff;
      end
   end

   // sqrt load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff[0] <= 1'b0;
      end else if (adv) begin
         vq_ff[0] <= v6_ff;
      end
      if (adv) begin
         dsh_ff[0]         <= d_ff[D_W-1] ? '0 : d_ff;
         rem_ff[0]         <= '0;
         root_ff[0]        <= '0;
         side_ff[0].hd     <= hd6_ff;
         side_ff[0].c_pos  <= cpos6_ff;
         side_ff[0].c_neg  <= cneg6_ff;
         side_ff[0].d_neg  <= d_ff[D_W-1];
         side_ff[0].d_zero <= (d_ff == '0);
      end
   end

   // one root bit per stage
   for (genvar i = 1; i <= SQ_W; i++) begin : g_sqrt
      logic [SQ_W+1:0] rem_in, trial;
      logic            ge;
      assign rem_in = {rem_ff[i-1][SQ_W-1:0], dsh_ff[i-1][D_W-1:D_W-2]};
      assign trial  = {root_ff[i-1], 2'b01};
      assign ge     = rem_in >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            vq_ff[i] <= 1'b0;
         end else if (adv) begin
            vq_ff[i] <= vq_ff[i-1];
         end
         if (adv) begin
            rem_ff[i]  <= ge ? rem_in - trial : rem_in;
            root_ff[i] <= {root_ff[i-1][SQ_W-2:0], ge};
            dsh_ff[i]  <= dsh_ff[i-1] << 2;
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // root choice
   always_comb begin
      side_type                sd;
      logic signed [T_W-1:0]   nh, s;
      sd     = side_ff[SQ_W];
      nh     = -T_W'(sd.hd);
      s      = $signed({{(T_W-SQ_W){1'b0}}, root_ff[SQ_W]});
      hit_in = 1'b0;
      t_in   = '0;
      if (sd.d_neg) begin
         hit_in = 1'b0;
      end else if (sd.d_zero) begin
         hit_in = 1'b1;
         t_in   = nh;
      end else if (sd.hd[HD_W-1] && sd.c_pos) begin
         hit_in = 1'b1;
         t_in   = nh - s;
      end else if (sd.hd[HD_W-1] || sd.c_neg) begin
         hit_in = 1'b1;
         t_in   = nh + s;
      end
   end

   // floor scaling and saturation
   assign q = tf_ff >>> FRAC_BITS;

   // in range when the distance sign bit and all bits above it match the top bit
   always_comb begin
      if (!q[T_W-1] && (q[T_W-2:DIST_W-1] != '0)) begin
         dist_in = {1'b0, {(DIST_W-1){1'b1}}};
      end else if (q[T_W-1] && (q[T_W-2:DIST_W-1] != '1)) begin
         dist_in = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         dist_in = q[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hitf_ff <= hit_in;
         tf_ff   <= t_in;
         hit_ff  <= hitf_ff;
         dist_ff <= hitf_ff ? dist_in : '0;
      end
   end
endmodule
`default_nettype wire

>>> sv/rsi_port_check.sv
// rsi_port_check: port-level assertions for ray_sphere_intersect, bound to the top level.
// Depends on rsi_pkg for the payload widths.
`default_nettype none
module rsi_port_check import rsi_pkg::*; (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tready,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [8*RSP_BYTES-1:0]  rsp_tdata
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[DIST_W:1] == '0)
      else $error("miss with nonzero distance");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8*RSP_BYTES-1:RSP_W] == '0)
      else $error("result padding not zero");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
endmodule

bind ray_sphere_intersect rsi_port_check u_rsi_port_check (.*);
`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for ray_sphere_intersect, streaming ray/sphere items
// through the pipeline with random idling and a long result hold-off. Depends on rsi_pkg.
`default_nettype none
module testbench;
   import rsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 1930;
   localparam int CALM_AFTER = 1750;
   localparam int ONE        = 1 << FRAC_BITS;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [8*REQ_BYTES-1:0]   req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [8*RSP_BYTES-1:0]   rsp_tdata;

   logic [8*REQ_BYTES-1:0]   pending_rays[$];
   logic [RSP_W-1:0]         expected_hits[$];
   int                       error_count;
   int                       sent_count;
   int                       recv_count;
   int                       send_gap;
   int                       recv_gap;
   int                       hold_left;
   bit                       hold_done;

   ray_sphere_intersect u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [8*REQ_BYTES-1:0] pack_ray(
      input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
      input logic [17:0] dx, input logic [17:0] dy, input logic [17:0] dz,
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
      input logic [30:0] rad);
      logic [8*REQ_BYTES-1:0] v;
      v = '0;
      v[REQ_W-1:0] = {rad, cz, cy, cx, dz, dy, dx, oz, oy, ox};
      return v;
   endfunction

   // Nearest positive root of |o+t*d-c| = r or a tangent's root; exact wide integer math.
   function automatic logic [RSP_W-1:0] nearest_hit(input logic [8*REQ_BYTES-1:0] v);
      logic signed [127:0] oc[3];
      logic signed [127:0] hd;
      logic signed [127:0] cc;
      logic signed [127:0] rr;
      logic signed [127:0] disc;
      logic signed [127:0] t;
      logic signed [127:0] q;
      logic [127:0]        root;
      logic [127:0]        trial;
      logic                hit;
      hd = 0;
      cc = 0;
      t  = 0;
      hit = 1'b0;
      for (int i = 0; i < 3; i++) begin
         oc[i] = 128'($signed(v[32*i +: 32])) - 128'($signed(v[150 + 32*i +: 32]));
         hd += 128'($signed(v[96 + 18*i +: 18])) * oc[i];
         cc += oc[i] * oc[i];
      end
      rr = 128'(v[246 +: 31]);
      cc = cc - rr * rr;
      disc = hd * hd - (cc <<< (2*FRAC_BITS));
      if (disc < 0) begin
         hit = 1'b0;
      end else if (disc == 0) begin
         hit = 1'b1;
         t = -hd;
      end else begin
         root = 0;
         for (int b = 59; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= 128'(disc)) root = trial;
         end
         if (hd < 0 && cc > 0) begin
            hit = 1'b1;
            t = -hd - $signed(root);
         end else if (hd < 0 || cc < 0) begin
            hit = 1'b1;
            t = -hd + $signed(root);
         end
      end
      q = t >>> FRAC_BITS;
      if (q > 128'sd2147483647) q = 128'sd2147483647;
      if (q < -128'sd2147483648) q = -128'sd2147483648;
      if (!hit) q = 0;
      return {q[31:0], hit};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", recv_count, what, got, want);
      error_count++;
   endtask

   function automatic logic [17:0] rand_dir();
      return 18'($signed($urandom_range(0, 2*ONE)) - ONE);
   endfunction

   // Sphere placed near the ray, ahead or behind, so most items reach the root logic.
   function automatic logic [8*REQ_BYTES-1:0] scene_ray();
      logic signed [31:0] o[3];
      logic signed [31:0] cen[3];
      logic [17:0]        d[3];
      int                 k;
      int                 span;
      span = ($urandom_range(0, 9) == 0) ? 30 : 22;
      k = $signed($urandom_range(0, 80)) - 20;
      for (int i = 0; i < 3; i++) begin
         o[i] = $signed($urandom_range(0, (1 << span))) - (1 << (span-1));
         d[i] = rand_dir();
         cen[i] = o[i] + k * $signed(d[i]) + ($signed($urandom_range(0, 2*ONE)) - ONE);
      end
      return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2], cen[0], cen[1], cen[2],
                      31'($urandom_range(0, 4*ONE)));
   endfunction

   initial begin
      error_count = 0;
      reset = 1'b1;
      // all-zero ray and point sphere
      pending_rays.push_back(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // tangent ahead, tangent behind
      pending_rays.push_back(pack_ray(0, 0, 0, 18'(ONE), 0, 0, 5*ONE, ONE, 0, 31'(ONE)));
      pending_rays.push_back(pack_ray(0, 0, 0, 18'(ONE), 0, 0, -5*ONE, ONE, 0, 31'(ONE)));
      // clean hit ahead, sphere behind, miss, origin inside
      pending_rays.push_back(pack_ray(0, 0, 0, 0, 0, 18'(ONE), 0, 0, 10*ONE, 31'(2*ONE)));
      pending_rays.push_back(pack_ray(0, 0, 0, 0, 0, 18'(ONE), 0, 0, -10*ONE, 31'(2*ONE)));
      pending_rays.push_back(pack_ray(0, 0, 0, 0, 18'(ONE), 0, 9*ONE, 0, 0, 31'(ONE)));
      pending_rays.push_back(pack_ray(ONE, 0, 0, 18'(-ONE), 0, 0, 0, 0, 0, 31'(3*ONE)));
      // origin on the surface: one root exactly zero
      pending_rays.push_back(pack_ray(0, 0, 0, 18'(ONE), 0, 0, 2*ONE, 0, 0, 31'(2*ONE)));
      pending_rays.push_back(pack_ray(0, 0, 0, 18'(-ONE), 0, 0, 2*ONE, 0, 0, 31'(2*ONE)));
      // field extremes and saturation
      pending_rays.push_back(pack_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      18'h1ffff, 18'h1ffff, 18'h1ffff,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      31'h7fffffff));
      pending_rays.push_back(pack_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                      18'h20000, 18'h20000, 18'h20000,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      31'h7fffffff));
      pending_rays.push_back(pack_ray(32'h80000000, 0, 0, 18'(ONE), 0, 0,
                                      32'h7fffffff, 0, 0, 31'h7fffffff));
      pending_rays.push_back(pack_ray(32'h7fffffff, 0, 0, 18'(ONE), 0, 0,
                                      32'h80000000, 0, 0, 31'h7fffffff));
      pending_rays.push_back(pack_ray(0, 0, 0, 18'h3ffff, 18'h3ffff, 18'h3ffff,
                                      1, 1, 1, 31'h7fffffff));
      pending_rays.push_back(pack_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                      18'h20000, 18'h1ffff, 18'h0, 0, 0, 0, 31'h1));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if ($urandom_range(0, 3) == 0)
            pending_rays.push_back(pack_ray($urandom, $urandom, $urandom,
                                            18'($urandom), 18'($urandom), 18'($urandom),
                                            $urandom, $urandom, $urandom,
                                            31'($urandom)));
         else
            pending_rays.push_back(scene_ray());
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_rays.size() != 0 || req_tvalid || expected_hits.size() != 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Driver: offer the next item, with random gaps until the calm tail.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
         sent_count <= 0;
      end else if (!req_tvalid || req_tready) begin
         next_valid = 1'b0;
         if (req_tvalid) sent_count <= sent_count + 1;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_rays.size() != 0) begin
            req_tdata  <= pending_rays.pop_front();
            next_valid = 1'b1;
            if (sent_count < CALM_AFTER && $urandom_range(0, 11) == 0)
               send_gap <= $urandom_range(1, 13);
         end
         req_tvalid <= next_valid;
      end
   end

   // Record the expectation for every accepted item.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_hits.push_back(nearest_hit(req_tdata));
   end

   // Long hold-off: count the stretch in which the receiver backs up the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= 400) begin
         hold_done <= 1'b1;
         hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: random stalls, and ready held low throughout the hold-off.
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_count <= 0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[32:1], 32'd0);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tdata[0] !== want[0])
                  report_mismatch("hit", 32'(rsp_tdata[0]), 32'(want[0]));
               if (rsp_tdata[32:1] !== want[32:1])
                  report_mismatch("distance", rsp_tdata[32:1], want[32:1]);
            end
            recv_count <= recv_count + 1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (recv_count < CALM_AFTER && $urandom_range(0, 9) == 0) begin
            recv_gap   <= $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end
endmodule
`default_nettype wire
